FILE: hdl/rwf_pkg.sv
// Package for the replay window filter: request, command and result types,
// ledger sizing, queue sizing, window reset value and operation codes.
// No dependencies; every other file imports this package.
package rwf_pkg;

    // Ledger sizing
    localparam int LEDGER_ENTRIES = 16;
    localparam int IDX_W          = (LEDGER_ENTRIES > 1) ? $clog2(LEDGER_ENTRIES) : 1;
    localparam int SLOT_W         = 6;

    // Command queue between front and back
    localparam int QDEPTH = 2;
    localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // Window register reset value
    localparam logic [31:0] WINDOW_RESET = 32'd60;

    // Operation codes
    localparam logic OP_CHECK  = 1'b0;
    localparam logic OP_INSERT = 1'b1;

    typedef logic [IDX_W-1:0]  t_idx;
    typedef logic [SLOT_W-1:0] t_slot;

    // Request as it arrives on the ports
    typedef struct packed {
        logic        req_type;
        logic [63:0] id_high;
        logic [63:0] id_low;
        logic [63:0] now_seconds;
    } t_req;

    // Classified command held in the queue
    typedef struct packed {
        logic        op;
        logic [63:0] id_high;
        logic [63:0] id_low;
        logic [63:0] now_seconds;
    } t_cmd;

    // Result as it leaves on the ports
    typedef struct packed {
        logic  duplicate;
        logic  stored;
        t_slot slot_written;
    } t_res;

endpackage

FILE: hdl/rwf_front.sv
// Front end of the replay window filter: accepts requests, classifies them
// into commands and holds them in a short queue for the scan engine.
// Depends on rwf_pkg.
module rwf_front
    import rwf_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_start,
    input  t_req i_req,
    output logic o_busy,
    output logic o_cmd_valid,
    output t_cmd o_cmd,
    input  logic i_cmd_pop
);

    t_cmd              r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wptr, n_wptr;
    logic [QPTR_W-1:0] r_rptr, n_rptr;
    logic [QCNT_W-1:0] r_count;
    logic              push;
    t_cmd              cmd_in;

    // Classify the incoming request
    always_comb begin
        cmd_in.op          = i_req.req_type ? OP_INSERT : OP_CHECK;
        cmd_in.id_high     = i_req.id_high;
        cmd_in.id_low      = i_req.id_low;
        cmd_in.now_seconds = i_req.now_seconds;
    end

    assign o_busy      = (r_count == QCNT_W'(QDEPTH));
    assign push        = i_start && !o_busy;
    assign o_cmd_valid = (r_count != '0);
    assign o_cmd       = r_mem[r_rptr];

    // Advance pointers with wrap at the queue depth
    always_comb begin
        n_wptr = (r_wptr == QPTR_W'(QDEPTH - 1)) ? '0 : r_wptr + 1'b1;
        n_rptr = (r_rptr == QPTR_W'(QDEPTH - 1)) ? '0 : r_rptr + 1'b1;
    end

    // Queue control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (push) begin
                r_wptr <= n_wptr;
            end
            if (i_cmd_pop) begin
                r_rptr <= n_rptr;
            end
            if (push && !i_cmd_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!push && i_cmd_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // Queue storage
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wptr] <= cmd_in;
        end
    end

`ifndef SYNTH
    // Fill level never exceeds the queue depth
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= QCNT_W'(QDEPTH))
        else $error("command queue overfilled");

    // Never pop an empty queue
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd_pop |-> (r_count != '0))
        else $error("pop from empty command queue");

    // An accepted item raises the fill level unless one leaves at once
    a_push_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push && !i_cmd_pop) |=> (r_count == $past(r_count) + 1'b1))
        else $error("accepted item not counted");
`endif

endmodule

FILE: hdl/rwf_scan.sv
// Back end of the replay window filter: holds the ledger and scans it one
// entry per cycle for each command, then writes back and reports a result.
// Depends on rwf_pkg.
module rwf_scan
    import rwf_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic [31:0] i_window,
    input  logic        i_cmd_valid,
    input  t_cmd        i_cmd,
    output logic        o_cmd_pop,
    output logic        o_res_valid,
    output t_res        o_res
);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_SCAN = 1'b1;

    // Ledger
    logic [LEDGER_ENTRIES-1:0] r_valid;
    logic [63:0]               r_id_hi [LEDGER_ENTRIES];
    logic [63:0]               r_id_lo [LEDGER_ENTRIES];
    logic [63:0]               r_seen  [LEDGER_ENTRIES];

    // Scan state
    logic        r_state;
    t_idx        r_idx;
    t_cmd        r_cmd;
    logic        r_have_best;
    logic [63:0] r_best_time;
    t_idx        r_target;
    logic        r_res_valid;
    t_res        r_res;

    logic        rd_valid;
    logic [63:0] rd_seen;
    logic [63:0] age;
    logic        live, match, is_ins, hit, free, take_best, last, finish, do_write;
    t_idx        fin_target;

    // Examine the entry under the scan index
    always_comb begin
        rd_valid   = r_valid[r_idx];
        rd_seen    = r_seen[r_idx];
        age        = r_cmd.now_seconds - rd_seen;
        live       = rd_valid && (age <= {32'd0, i_window});
        match      = (r_id_hi[r_idx] == r_cmd.id_high) && (r_id_lo[r_idx] == r_cmd.id_low);
        is_ins     = (r_cmd.op == OP_INSERT);
        hit        = live && match;
        free       = is_ins && !live;
        take_best  = is_ins && live && !match &&
                     (!r_have_best || (rd_seen < r_best_time));
        last       = (r_idx == IDX_W'(LEDGER_ENTRIES - 1));
        finish     = (r_state == S_SCAN) && (hit || free || last);
        fin_target = (free || take_best) ? r_idx : r_target;
        do_write   = finish && is_ins && !hit;
    end

    assign o_cmd_pop   = (r_state == S_IDLE) && i_cmd_valid;
    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;

    // Sequencer, valid bits and result strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_valid     <= '0;
            r_have_best <= 1'b0;
            r_res_valid <= 1'b0;
        end else begin
            r_res_valid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (o_cmd_pop) begin
                        r_have_best <= 1'b0;
                        r_state     <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (take_best) begin
                        r_have_best <= 1'b1;
                    end
                    if (finish) begin
                        r_res_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
            if (do_write) begin
                r_valid[fin_target] <= 1'b1;
            end
        end
    end

    // Scan datapath, result payload and ledger write-back
    always_ff @(posedge i_clk) begin
        if (o_cmd_pop) begin
            r_cmd <= i_cmd;
            r_idx <= '0;
        end else if (r_state == S_SCAN && !finish) begin
            r_idx <= r_idx + 1'b1;
        end
        if (take_best) begin
            r_best_time <= rd_seen;
            r_target    <= r_idx;
        end
        if (finish) begin
            r_res.duplicate    <= hit;
            r_res.stored       <= do_write;
            r_res.slot_written <= do_write ? t_slot'(fin_target) : '0;
        end
        if (do_write) begin
            r_id_hi[fin_target] <= r_cmd.id_high;
            r_id_lo[fin_target] <= r_cmd.id_low;
            r_seen[fin_target]  <= r_cmd.now_seconds;
        end
    end

`ifndef SYNTH
    // A result never both rejects and stores
    a_dup_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_res_valid |-> !(r_res.duplicate && r_res.stored))
        else $error("result both duplicate and stored");

    // Nothing stored means slot zero
    a_slot_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_res_valid && !r_res.stored) |-> (r_res.slot_written == '0))
        else $error("slot reported without a store");

    // A check command never writes the ledger
    a_check_ro: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN && r_cmd.op == OP_CHECK) |-> !do_write)
        else $error("check command wrote the ledger");

    // Each scan ends in exactly one result strobe, one cycle long
    a_one_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_res_valid |=> !r_res_valid)
        else $error("result strobe held longer than one cycle");
`endif

endmodule

FILE: hdl/replay_window_filter_unit.sv
// Replay window filter top level: window register, request front end and
// ledger scan engine.
// Depends on rwf_pkg, rwf_front and rwf_scan.
//
// The block keeps a ledger of LEDGER_ENTRIES message identifiers with the
// time each was seen. Raise start with a request on i_req while busy is low;
// busy rises only when the two-deep request queue is full. The scan engine
// takes one queued request per pass: it loads the request, then examines one
// ledger entry per cycle, stopping early at the first live match (and, for an
// insert, at the first free or stale entry), and only then takes the next
// request. Each request yields one result on o_res, shown for exactly one
// cycle with o_res_valid high; there is no way to hold it off, so sample it
// when the strobe is high. The window register is written with i_cfg_we and
// i_cfg_wdata; the user must write it only while no request is outstanding,
// as the block itself does not enforce this. No clearing pass is needed
// after reset.
module replay_window_filter_unit
    import rwf_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  t_req        i_req,
    input  logic        i_cfg_we,
    input  logic [31:0] i_cfg_wdata,
    output logic        o_res_valid,
    output t_res        o_res
);

    logic [31:0] r_window;
    logic        cmd_valid;
    logic        cmd_pop;
    t_cmd        cmd;

    // Hold the window register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window <= WINDOW_RESET;
        end else if (i_cfg_we) begin
            r_window <= i_cfg_wdata;
        end
    end

    // Accept and queue requests
    rwf_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_req       (i_req),
        .o_busy      (busy),
        .o_cmd_valid (cmd_valid),
        .o_cmd       (cmd),
        .i_cmd_pop   (cmd_pop)
    );

    // Scan the ledger and report
    rwf_scan u_scan (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_window    (r_window),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd),
        .o_cmd_pop   (cmd_pop),
        .o_res_valid (o_res_valid),
        .o_res       (o_res)
    );

endmodule

FILE: bench/replay_window_filter_unit_tb.sv
`timescale 1ns / 1ps
// Testbench for replay_window_filter_unit: directed and random ledger requests
// checked against an in-bench ledger predictor. Depends on rwf_pkg.
module replay_window_filter_unit_tb;
    import rwf_pkg::*;

    localparam int PHASE_ITEMS   = 278;
    localparam int ID_POOL       = 20;
    localparam int SETTLE_CYCLES = 20;
    localparam int TAIL_CYCLES   = 40;
    localparam int STALL_LIMIT   = 2000;
    localparam int MAX_GAP       = 18;

    // One pending driver entry: a request or a window register write
    typedef struct {
        bit          is_cfg;
        logic [31:0] cfg_val;
        t_req        req;
        int unsigned gap;
    } t_pend;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        start       = 1'b0;
    logic        busy;
    t_req        i_req       = '0;
    logic        i_cfg_we    = 1'b0;
    logic [31:0] i_cfg_wdata = '0;
    logic        o_res_valid;
    t_res        o_res;

    // Driver state
    t_pend       pend_q[$];
    logic        req_taken   = 1'b0;
    int unsigned gap_left    = 0;
    bit          gap_armed   = 1'b0;
    int unsigned settle_cnt  = 0;
    bit          no_gap      = 1'b0;

    // Predicted ledger and window register
    logic        led_valid [LEDGER_ENTRIES];
    logic [63:0] led_hi    [LEDGER_ENTRIES];
    logic [63:0] led_lo    [LEDGER_ENTRIES];
    logic [63:0] led_seen  [LEDGER_ENTRIES];
    logic [31:0] win_sec;
    t_res        verdict_q[$];

    // Run statistics
    int unsigned n_taken    = 0;
    int unsigned n_results  = 0;
    int unsigned n_dup      = 0;
    int unsigned n_stored   = 0;
    int unsigned n_windows  = 0;
    int unsigned err_cnt    = 0;
    int unsigned idle_cyc   = 0;

    replay_window_filter_unit uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_req       (i_req),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_res_valid (o_res_valid),
        .o_res       (o_res)
    );

    always #1 i_clk = ~i_clk;

    // Scan the predicted ledger for one request and apply its write
    function automatic t_res ledger_step(input t_req rq);
        t_res        r;
        logic        hit;
        logic        have_best;
        logic [63:0] best;
        logic [63:0] age;
        logic        live;
        int          tgt;
        r = '0;
        hit = 1'b0;
        have_best = 1'b0;
        best = '0;
        tgt = 0;
        for (int i = 0; i < LEDGER_ENTRIES; i++) begin
            age  = rq.now_seconds - led_seen[i];
            live = led_valid[i] && (age <= {32'd0, win_sec});
            if (live && led_hi[i] == rq.id_high && led_lo[i] == rq.id_low) begin
                hit = 1'b1;
                break;
            end
            if (rq.req_type == OP_INSERT) begin
                if (!live) begin
                    tgt = i;
                    break;
                end
                if (!have_best || led_seen[i] < best) begin
                    have_best = 1'b1;
                    best = led_seen[i];
                    tgt = i;
                end
            end
        end
        r.duplicate = hit;
        if (rq.req_type == OP_INSERT && !hit) begin
            led_valid[tgt]  = 1'b1;
            led_hi[tgt]     = rq.id_high;
            led_lo[tgt]     = rq.id_low;
            led_seen[tgt]   = rq.now_seconds;
            r.stored        = 1'b1;
            r.slot_written  = t_slot'(tgt);
        end
        return r;
    endfunction

    // Driver: present requests and window writes at the falling edge
    always @(negedge i_clk) begin
        logic        nx_start;
        t_req        nx_req;
        logic        nx_we;
        logic [31:0] nx_wd;
        nx_start = start;
        nx_req   = i_req;
        nx_we    = 1'b0;
        nx_wd    = i_cfg_wdata;
        if (i_rst_n && !(start && !req_taken)) begin
            nx_start = 1'b0;
            if (pend_q.size() > 0) begin
                if (pend_q[0].is_cfg) begin
                    // hold the write until every result is in and the engine settled
                    if (verdict_q.size() == 0 && !start)
                        settle_cnt++;
                    else
                        settle_cnt = 0;
                    if (settle_cnt >= SETTLE_CYCLES) begin
                        nx_we = 1'b1;
                        nx_wd = pend_q[0].cfg_val;
                        pend_q.pop_front();
                        settle_cnt = 0;
                    end
                end else begin
                    if (!gap_armed) begin
                        gap_left  = pend_q[0].gap;
                        gap_armed = 1'b1;
                    end
                    if (gap_left > 0) begin
                        gap_left--;
                    end else begin
                        nx_start  = 1'b1;
                        nx_req    = pend_q[0].req;
                        pend_q.pop_front();
                        gap_armed = 1'b0;
                    end
                end
            end
        end
        start       <= nx_start;
        i_req       <= nx_req;
        i_cfg_we    <= nx_we;
        i_cfg_wdata <= nx_wd;
    end

    // Monitor: check results, predict accepted items, watch for stalls
    always @(posedge i_clk) begin
        t_res want;
        req_taken <= i_rst_n && start && !busy;
        if (!i_rst_n) begin
            win_sec = WINDOW_RESET;
            for (int i = 0; i < LEDGER_ENTRIES; i++)
                led_valid[i] = 1'b0;
        end else begin
            if (o_res_valid) begin
                n_results++;
                if (o_res.duplicate === 1'b1)
                    n_dup++;
                if (o_res.stored === 1'b1)
                    n_stored++;
                if (verdict_q.size() == 0) begin
                    if (err_cnt < 10)
                        $display("unexpected result: dup=%0b stored=%0b slot=%0d",
                                 o_res.duplicate, o_res.stored, o_res.slot_written);
                    err_cnt++;
                end else begin
                    want = verdict_q.pop_front();
                    if (o_res.duplicate !== want.duplicate || o_res.stored !== want.stored
                        || o_res.slot_written !== want.slot_written) begin
                        if (err_cnt < 10)
                            $display("mismatch on result %0d: expected dup=%0b stored=%0b slot=%0d, got dup=%0b stored=%0b slot=%0d",
                                     n_results, want.duplicate, want.stored,
                                     want.slot_written, o_res.duplicate, o_res.stored,
                                     o_res.slot_written);
                        err_cnt++;
                    end
                end
            end
            if (i_cfg_we)
                win_sec = i_cfg_wdata;
            if (start && !busy) begin
                n_taken++;
                verdict_q.push_back(ledger_step(i_req));
            end
            // Count cycles with no handshake of any kind
            if ((start && !busy) || o_res_valid || i_cfg_we)
                idle_cyc = 0;
            else
                idle_cyc++;
            if (idle_cyc >= STALL_LIMIT) begin
                $display("timeout: no progress for %0d cycles", STALL_LIMIT);
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    // Stimulus
    task automatic add_req(input logic op, input logic [63:0] hi, input logic [63:0] lo,
                           input logic [63:0] now);
        t_pend p;
        p.is_cfg          = 1'b0;
        p.cfg_val         = '0;
        p.req.req_type    = op;
        p.req.id_high     = hi;
        p.req.id_low      = lo;
        p.req.now_seconds = now;
        p.gap             = no_gap ? 0 : $urandom_range(0, MAX_GAP);
        pend_q.push_back(p);
    endtask

    task automatic add_window(input logic [31:0] val);
        t_pend p;
        p.is_cfg  = 1'b1;
        p.cfg_val = val;
        p.req     = '0;
        p.gap     = 0;
        pend_q.push_back(p);
        n_windows++;
    endtask

    initial begin
        logic [127:0] pool [ID_POOL];
        logic [127:0] id;
        logic [63:0]  t_now;
        logic [31:0]  windows [7];
        logic [31:0]  w;
        int unsigned  step_max;
        int unsigned  roll;
        int unsigned  k;
        logic         op;

        // Directed part, window at its reset value
        add_req(OP_CHECK,  64'd0, 64'd0, 64'd0);
        add_req(OP_INSERT, 64'd0, 64'd0, 64'd0);
        add_req(OP_INSERT, 64'd0, 64'd0, 64'd60);     // age equals window: still live
        add_req(OP_CHECK,  64'd0, 64'd0, 64'd61);     // one past the window: stale
        add_req(OP_INSERT, '1, '1, 64'd50);
        add_req(OP_INSERT, 64'h8000_0000_0000_0000, 64'd1, 64'd50);
        // stale entry 0 ends the scan before the live copy in entry 2
        add_req(OP_INSERT, 64'h8000_0000_0000_0000, 64'd1, 64'd70);
        add_req(OP_CHECK,  64'h8000_0000_0000_0000, 64'd1, 64'd70);
        // time runs backwards: entry 0 ages past the window by wrap
        add_req(OP_INSERT, 64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210, 64'd10);
        // fill the rest, then overflow into the oldest entries
        for (k = 3; k < LEDGER_ENTRIES; k++)
            add_req(OP_INSERT, 64'(k) << 8, ~64'(k), 64'd55);
        add_req(OP_INSERT, 64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555, 64'd56);
        add_req(OP_INSERT, 64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA, 64'd57);
        add_req(OP_INSERT, 64'hDEAD_0000_0000_BEEF, 64'd7, '1);

        // Random phases, one window setting each
        windows[0] = 32'd0;
        windows[1] = 32'hFFFF_FFFF;
        windows[2] = 32'd8;
        windows[3] = 32'($urandom_range(1, 200));
        windows[4] = 32'd1;
        windows[5] = $urandom();
        windows[6] = 32'd300;
        for (int i = 0; i < ID_POOL; i++)
            pool[i] = {$urandom(), $urandom(), $urandom(), $urandom()};
        t_now = {$urandom(), $urandom()};
        for (int ph = 0; ph < 7; ph++) begin
            w = windows[ph];
            add_window(w);
            step_max = (w < 4) ? 1 : ((w > 64) ? 16 : w / 4);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (n % 50 == 0)
                    no_gap = ($urandom_range(0, 3) == 0);
                // advance time, with rare jumps
                roll = $urandom_range(0, 99);
                case (roll)
                    0: t_now = {$urandom(), $urandom()};
                    1: t_now = t_now - $urandom_range(1, 500);
                    2: t_now = t_now + {32'd0, w} + 64'd1 + $urandom_range(0, 50);
                    3: t_now = '1 - $urandom_range(0, 40);
                    default: t_now = t_now + $urandom_range(0, step_max);
                endcase
                // pick an identifier: mostly from the pool, some near misses
                roll = $urandom_range(0, 99);
                if (roll < 60) begin
                    id = pool[$urandom_range(0, ID_POOL - 1)];
                end else if (roll < 70) begin
                    id = pool[$urandom_range(0, ID_POOL - 1)];
                    id[$urandom_range(0, 127)] ^= 1'b1;
                end else begin
                    id = {$urandom(), $urandom(), $urandom(), $urandom()};
                    pool[$urandom_range(0, ID_POOL - 1)] = id;
                end
                op = ($urandom_range(0, 99) < 65) ? OP_INSERT : OP_CHECK;
                add_req(op, id[127:64], id[63:0], t_now);
            end
        end

        // Reset once, then let the driver run the queue dry
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        while (pend_q.size() != 0 || start || verdict_q.size() != 0)
            @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Ran %0d requests under %0d window writes plus the reset window.",
                 n_taken, n_windows);
        $display("Saw %0d results: %0d duplicates, %0d stores, %0d mismatches.",
                 n_results, n_dup, n_stored, err_cnt);
        if (err_cnt == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

FILE: sim.f
hdl/rwf_pkg.sv
hdl/rwf_front.sv
hdl/rwf_scan.sv
hdl/replay_window_filter_unit.sv
bench/replay_window_filter_unit_tb.sv
